// ----- hw/rtl/shli_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// shli_pkg
// Shared constants and the sine table generator for the slew limited
// heading integrator.
// ----------------------------------------------------------------------------
package shli_pkg;

    // configuration port geometry
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_WALK_LIMIT = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_WALK_STEP  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_TURN_LIMIT = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_TURN_STEP  = 3'd3;

    // configuration reset values
    localparam logic [15:0] WALK_LIMIT_RST = 16'd13107;
    localparam logic [15:0] WALK_STEP_RST  = 16'd1966;
    localparam logic [13:0] TURN_LIMIT_RST = 14'd834;
    localparam logic [13:0] TURN_STEP_RST  = 14'd261;

    // pi/2 and one half in Q30
    localparam longint unsigned PI_HALF_Q30  = 64'd1686629713;
    localparam longint          HALF_Q30     = 64'sd536870912;
    localparam logic [14:0]     SINE_MAX     = 15'd32767;

    // one entry of the quarter-wave sine table, evaluated at elaboration:
    // taylor series through x^15 in Q30 with each term truncated, then
    // rounded to Q1.15 and clamped
    function automatic logic [14:0] quarter_entry(input int unsigned q,
                                                  input int unsigned tbits);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint          s;
        longint          v;
        int              n;
        x  = (longint'(q) * PI_HALF_Q30) >> (tbits - 2);
        x2 = (x * x) >> 30;
        t  = x;
        s  = longint'(x);
        for (n = 1; n <= 7; n++)
        begin
            t = (t * x2) >> 30;
            case (n)
                1:       t = t / 6;
                2:       t = t / 20;
                3:       t = t / 42;
                4:       t = t / 72;
                5:       t = t / 110;
                6:       t = t / 156;
                default: t = t / 210;
            endcase
            if (n % 2 == 1)
                s = s - longint'(t);
            else
                s = s + longint'(t);
        end
        if (s < 0)
            s = 0;
        v = (s * 32767 + HALF_Q30) >>> 30;
        if (v > 32767)
            v = 32767;
        return 15'(v);
    endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/shli_in_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// shli_in_if
// Command channel: advance or set-position transaction with its demands.
// ----------------------------------------------------------------------------
interface shli_in_if;
    logic               valid;
    logic               ready;
    logic               cmd;
    logic signed [15:0] walk_demand;
    logic signed [15:0] turn_demand;
    logic signed [31:0] new_x;
    logic signed [31:0] new_y;

    modport source (output valid, output cmd, output walk_demand,
                    output turn_demand, output new_x, output new_y,
                    input ready);
    modport sink   (input valid, input cmd, input walk_demand,
                    input turn_demand, input new_x, input new_y,
                    output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/shli_out_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// shli_out_if
// Result channel: vehicle state after each command transaction.
// ----------------------------------------------------------------------------
interface shli_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] position_x;
    logic signed [31:0] position_y;
    logic        [15:0] heading_phase;
    logic signed [15:0] direction_x;
    logic signed [15:0] direction_y;
    logic signed [16:0] walk_rate;
    logic signed [14:0] turn_rate;

    modport source (output valid, output position_x, output position_y,
                    output heading_phase, output direction_x,
                    output direction_y, output walk_rate, output turn_rate,
                    input ready);
    modport sink   (input valid, input position_x, input position_y,
                    input heading_phase, input direction_x,
                    input direction_y, input walk_rate, input turn_rate,
                    output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/slew_limited_heading_integrator.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// slew_limited_heading_integrator
// Dead reckoning for a ground vehicle with slew limited walk and turn speeds.
// ----------------------------------------------------------------------------
// An advance transaction steps from acceptance through the walk and turn
// products, the two slews, the heading, sine and cosine and the two position
// steps to a loaded result register; a set-position transaction goes from
// acceptance straight to the emit step. The sequencer returns to idle before
// the next transaction is taken. One 18x18 signed multiplier is stepped by a
// small sequencer through four products per advance (walk target, turn
// target, x step, y step), and the quarter-wave sine table is read once per
// cycle for sine and then cosine. The block takes a new transaction only
// while the sequencer is idle; a finished result sits in the output
// register, so the next transaction may start while it waits to be taken. A
// result that is still waiting when the next one finishes holds the
// sequencer in its emit step. No clearing pass is needed after reset.
module slew_limited_heading_integrator #(
    parameter int SINE_TABLE_BITS = 10,
    parameter int HEADING_BITS    = 16
) (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire                                   cfg_we,
    input  wire [shli_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  wire [shli_pkg::CFG_DATA_W-1:0]        cfg_data,
    shli_in_if.sink                               item,
    shli_out_if.source                            result
);
    import shli_pkg::*;

    localparam int QUARTER_LEN = 1 << (SINE_TABLE_BITS - 2);
    localparam int TAB_AW      = SINE_TABLE_BITS - 1;

    // sequencer codes
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MW   = 4'd1;
    localparam logic [3:0] S_MT   = 4'd2;
    localparam logic [3:0] S_TS   = 4'd3;
    localparam logic [3:0] S_HD   = 4'd4;
    localparam logic [3:0] S_SIN  = 4'd5;
    localparam logic [3:0] S_COS  = 4'd6;
    localparam logic [3:0] S_MX   = 4'd7;
    localparam logic [3:0] S_MY   = 4'd8;
    localparam logic [3:0] S_PY   = 4'd9;
    localparam logic [3:0] S_EMIT = 4'd10;

    logic [3:0]               state_reg;
    logic [3:0]               state_next;

    // configuration registers
    logic [15:0]              walk_limit_reg;
    logic [15:0]              walk_step_reg;
    logic [13:0]              turn_limit_reg;
    logic [13:0]              turn_step_reg;

    // vehicle state
    logic signed [31:0]       pos_x_reg;
    logic signed [31:0]       pos_y_reg;
    logic [HEADING_BITS-1:0]  heading_reg;
    logic signed [17:0]       walk_speed_reg;
    logic signed [14:0]       turn_speed_reg;
    logic signed [15:0]       dir_x_reg;
    logic signed [15:0]       dir_y_reg;

    // working registers
    logic signed [15:0]       walk_dem_reg;
    logic signed [15:0]       turn_dem_reg;
    logic signed [35:0]       prod_reg;

    // result register
    logic                     out_valid_reg;
    logic signed [31:0]       out_x_reg;
    logic signed [31:0]       out_y_reg;
    logic [15:0]              out_phase_reg;
    logic signed [15:0]       out_dir_x_reg;
    logic signed [15:0]       out_dir_y_reg;
    logic signed [16:0]       out_walk_reg;
    logic signed [14:0]       out_turn_reg;

    logic                     item_acc;
    logic                     emit_go;

    assign item.ready = (state_reg == S_IDLE);
    assign item_acc   = item.valid && item.ready;
    assign emit_go    = (state_reg == S_EMIT) && (!out_valid_reg || result.ready);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (item_acc)
                    state_next = item.cmd ? S_EMIT : S_MW;
            end
            S_MW:    state_next = S_MT;
            S_MT:    state_next = S_TS;
            S_TS:    state_next = S_HD;
            S_HD:    state_next = S_SIN;
            S_SIN:   state_next = S_COS;
            S_COS:   state_next = S_MX;
            S_MX:    state_next = S_MY;
            S_MY:    state_next = S_PY;
            S_PY:    state_next = S_EMIT;
            S_EMIT:
            begin
                if (emit_go)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // shared multiplier operand select
    logic signed [17:0] mul_a;
    logic signed [17:0] mul_b;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_MW:
            begin
                mul_a = 18'(walk_dem_reg);
                mul_b = signed'({2'b00, walk_limit_reg});
            end
            S_MT:
            begin
                mul_a = 18'(turn_dem_reg);
                mul_b = signed'({4'b0000, turn_limit_reg});
            end
            S_MX:
            begin
                mul_a = 18'(dir_x_reg);
                mul_b = walk_speed_reg;
            end
            S_MY:
            begin
                mul_a = 18'(dir_y_reg);
                mul_b = walk_speed_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // floor of the registered product over 2^15
    logic signed [20:0] prod_shr;
    assign prod_shr = prod_reg[35:15];

    // shared slew unit: move cur toward target by at most step
    logic signed [19:0] slew_cur;
    logic signed [19:0] slew_step;
    logic signed [19:0] slew_tgt;
    logic signed [20:0] slew_diff;
    logic signed [20:0] slew_dcl;
    logic signed [20:0] slew_res;

    assign slew_tgt = prod_shr[19:0];

    always_comb
    begin
        if (state_reg == S_TS)
        begin
            slew_cur  = 20'(turn_speed_reg);
            slew_step = signed'({6'b0, turn_step_reg});
        end
        else
        begin
            slew_cur  = 20'(walk_speed_reg);
            slew_step = signed'({4'b0, walk_step_reg});
        end
        slew_diff = 21'(slew_tgt) - 21'(slew_cur);
        if (slew_diff > 21'(slew_step))
            slew_dcl = 21'(slew_step);
        else if (slew_diff < -21'(slew_step))
            slew_dcl = -21'(slew_step);
        else
            slew_dcl = slew_diff;
        slew_res = 21'(slew_cur) + slew_dcl;
    end

    // heading accumulate with wrap
    logic signed [31:0]      turn_ext;
    logic [HEADING_BITS-1:0] heading_sum;
    assign turn_ext    = 32'(turn_speed_reg);
    assign heading_sum = heading_reg + turn_ext[HEADING_BITS-1:0];

    // table index and 16-bit phase from the heading
    logic [SINE_TABLE_BITS-1:0] head_idx;
    logic [15:0]                phase16;

    if (HEADING_BITS >= SINE_TABLE_BITS)
    begin : g_idx_shr
        assign head_idx = heading_reg[HEADING_BITS-1 -: SINE_TABLE_BITS];
    end
    else
    begin : g_idx_shl
        assign head_idx = {heading_reg, {(SINE_TABLE_BITS-HEADING_BITS){1'b0}}};
    end

    if (HEADING_BITS >= 16)
    begin : g_ph_shr
        assign phase16 = heading_reg[HEADING_BITS-1 -: 16];
    end
    else
    begin : g_ph_shl
        assign phase16 = {heading_reg, {(16-HEADING_BITS){1'b0}}};
    end

    // quarter-wave sine table, one lookup per cycle
    logic [14:0] quarter_tab [QUARTER_LEN+1];

    for (genvar g = 0; g <= QUARTER_LEN; g++)
    begin : g_tab
        assign quarter_tab[g] = quarter_entry(g, SINE_TABLE_BITS);
    end

    logic [SINE_TABLE_BITS-1:0] look_idx;
    logic [1:0]                 look_quad;
    logic [TAB_AW-1:0]          look_r;
    logic [TAB_AW-1:0]          look_addr;
    logic [14:0]                look_mag;
    logic signed [15:0]         look_val;

    always_comb
    begin
        if (state_reg == S_COS)
            look_idx = head_idx + SINE_TABLE_BITS'(QUARTER_LEN);
        else
            look_idx = head_idx;
        look_quad = look_idx[SINE_TABLE_BITS-1 -: 2];
        look_r    = {1'b0, look_idx[SINE_TABLE_BITS-3:0]};
        if (look_quad[0])
            look_addr = TAB_AW'(QUARTER_LEN) - look_r;
        else
            look_addr = look_r;
        look_mag = quarter_tab[look_addr];
        if (look_quad[1])
            look_val = -signed'({1'b0, look_mag});
        else
            look_val = signed'({1'b0, look_mag});
    end

    // saturating position add
    logic signed [31:0] pos_sel;
    logic signed [32:0] pos_sum;
    logic signed [31:0] pos_sat;

    always_comb
    begin
        pos_sel = (state_reg == S_MY) ? pos_x_reg : pos_y_reg;
        pos_sum = 33'(pos_sel) + 33'(prod_shr);
        if (pos_sum[32] != pos_sum[31])
            pos_sat = pos_sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        else
            pos_sat = pos_sum[31:0];
    end

    // control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            walk_limit_reg <= WALK_LIMIT_RST;
            walk_step_reg  <= WALK_STEP_RST;
            turn_limit_reg <= TURN_LIMIT_RST;
            turn_step_reg  <= TURN_STEP_RST;
            pos_x_reg      <= '0;
            pos_y_reg      <= '0;
            heading_reg    <= '0;
            walk_speed_reg <= '0;
            turn_speed_reg <= '0;
            dir_x_reg      <= 16'(SINE_MAX);
            dir_y_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // configuration writes
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_WALK_LIMIT: walk_limit_reg <= cfg_data;
                    CFG_WALK_STEP:  walk_step_reg  <= cfg_data;
                    CFG_TURN_LIMIT: turn_limit_reg <= cfg_data[13:0];
                    CFG_TURN_STEP:  turn_step_reg  <= cfg_data[13:0];
                    default:        ;
                endcase
            end

            // set position on accept
            if (item_acc && item.cmd)
            begin
                pos_x_reg <= item.new_x;
                pos_y_reg <= item.new_y;
            end

            // speed, heading and direction steps
            if (state_reg == S_MT)
                walk_speed_reg <= slew_res[17:0];
            if (state_reg == S_TS)
                turn_speed_reg <= slew_res[14:0];
            if (state_reg == S_HD)
                heading_reg <= heading_sum;
            if (state_reg == S_SIN)
                dir_y_reg <= look_val;
            if (state_reg == S_COS)
                dir_x_reg <= look_val;
            if (state_reg == S_MY)
                pos_x_reg <= pos_sat;
            if (state_reg == S_PY)
                pos_y_reg <= pos_sat;

            // result register handshake
            if (emit_go)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (item_acc)
        begin
            walk_dem_reg <= item.walk_demand;
            turn_dem_reg <= item.turn_demand;
        end
        prod_reg <= mul_a * mul_b;
        if (emit_go)
        begin
            out_x_reg     <= pos_x_reg;
            out_y_reg     <= pos_y_reg;
            out_phase_reg <= phase16;
            out_dir_x_reg <= dir_x_reg;
            out_dir_y_reg <= dir_y_reg;
            out_walk_reg  <= walk_speed_reg[16:0];
            out_turn_reg  <= turn_speed_reg;
        end
    end

    // result channel
    assign result.valid         = out_valid_reg;
    assign result.position_x    = out_x_reg;
    assign result.position_y    = out_y_reg;
    assign result.heading_phase = out_phase_reg;
    assign result.direction_x   = out_dir_x_reg;
    assign result.direction_y   = out_dir_y_reg;
    assign result.walk_rate     = out_walk_reg;
    assign result.turn_rate     = out_turn_reg;

`ifndef SYNTHESIS
    // a new result only comes out of the emit step
    a_rise_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result.valid) |-> $past(state_reg) == S_EMIT)
        else $error("result valid rose outside the emit step");

    // heading moves only in the heading step
    a_heading_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_HD) |=> $stable(heading_reg))
        else $error("heading changed outside the heading step");

    // walk speed stays within the reachable range
    a_walk_range: assert property (@(posedge clk) disable iff (!rst_n)
        (walk_speed_reg <= 18'sd65535) && (walk_speed_reg >= -18'sd65535))
        else $error("walk speed out of range");

    // turn speed never reaches the most negative code
    a_turn_range: assert property (@(posedge clk) disable iff (!rst_n)
        turn_speed_reg != 15'sh4000)
        else $error("turn speed out of range");
`endif

endmodule
`default_nettype wire

// ----- dv/tb_slew_limited_heading_integrator.sv -----
// ----------------------------------------------------------------------------
// tb_slew_limited_heading_integrator
// Self-checking testbench for the slew limited heading integrator. A short
// table of directed commands runs first, then eight phases of random tick
// sequences. Each phase has its own register setting and idling pattern.
// Every result transaction is compared field by field with a software copy
// of the vehicle state: slewed speeds, wrapped heading, table direction and
// saturated position.
// ----------------------------------------------------------------------------
module tb_slew_limited_heading_integrator;

    import shli_pkg::*;

    // command codes
    localparam logic CMD_ADVANCE = 1'b0;
    localparam logic CMD_SET_POS = 1'b1;

    // first register index past the mapped ones
    localparam logic [CFG_INDEX_W-1:0] CFG_UNMAPPED_BASE = CFG_TURN_STEP + 3'd1;

    localparam int     CLK_HALF        = 10;
    localparam int     RESET_CYCLES    = 8;
    localparam int     QUARTER_LEN     = 256;
    localparam int     NUM_PHASES      = 8;
    localparam int     ITEMS_PER_PHASE = 200;
    localparam int     PAUSE_EVERY     = 50;
    localparam int     SETTLE_CYCLES   = 16;
    localparam int     DRAIN_CYCLES    = 40;
    localparam int     CYCLE_LIMIT     = 1000000;
    localparam longint PI_HALF         = 64'sd1686629713;
    localparam longint POS_MAX         = 64'sd2147483647;
    localparam longint POS_MIN         = -64'sd2147483648;

    typedef struct packed {
        logic               cmd;
        logic signed [15:0] walk_demand;
        logic signed [15:0] turn_demand;
        logic signed [31:0] new_x;
        logic signed [31:0] new_y;
    } command_t;

    typedef struct packed {
        logic signed [31:0] position_x;
        logic signed [31:0] position_y;
        logic        [15:0] heading_phase;
        logic signed [15:0] direction_x;
        logic signed [15:0] direction_y;
        logic signed [16:0] walk_rate;
        logic signed [14:0] turn_rate;
    } vehicle_state_t;

    typedef struct packed {
        command_t       command;
        logic           typed;
        vehicle_state_t state;
    } stim_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    shli_in_if  cmd_ch ();
    shli_out_if state_ch ();

    slew_limited_heading_integrator i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (cmd_ch),
        .result    (state_ch)
    );

    // register copies and vehicle state of the predictor
    logic        [15:0] walk_limit;
    logic        [15:0] walk_step;
    logic        [13:0] turn_limit;
    logic        [13:0] turn_step;
    logic signed [31:0] veh_x;
    logic signed [31:0] veh_y;
    logic        [15:0] veh_heading;
    longint             veh_walk;
    longint             veh_turn;

    logic signed [15:0] quarter_sine [0:QUARTER_LEN];
    vehicle_state_t     pending_states [$];

    int error_count    = 0;
    int cycle_count    = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // quarter-wave sine table: truncated taylor series in q30, rounded to q1.15
    initial
    begin : build_sine_table
        longint unsigned ang;
        longint unsigned ang2;
        longint unsigned term;
        longint          acc;
        longint          rounded;
        int              q;
        int              n;
        for (q = 0; q <= QUARTER_LEN; q++)
        begin
            ang  = (64'(q) * PI_HALF) >> 8;
            ang2 = (ang * ang) >> 30;
            term = ang;
            acc  = longint'(ang);
            for (n = 1; n <= 7; n++)
            begin
                term = ((term * ang2) >> 30) / 64'((2 * n) * (2 * n + 1));
                if (n % 2 == 1)
                    acc = acc - longint'(term);
                else
                    acc = acc + longint'(term);
            end
            if (acc < 0)
                acc = 0;
            rounded = (acc * 32767 + (64'sd1 <<< 29)) >>> 30;
            if (rounded > 32767)
                rounded = 32767;
            quarter_sine[q] = 16'(rounded);
        end
    end

    // signed sine of a 10-bit table index from the quarter wave
    function automatic logic signed [15:0] sine_of(input logic [9:0] idx);
        logic signed [15:0] mag;
        mag = idx[8] ? quarter_sine[QUARTER_LEN - int'(idx[7:0])] : quarter_sine[idx[7:0]];
        return idx[9] ? -mag : mag;
    endfunction

    // move a speed toward its target by at most step
    function automatic longint slewed(input longint cur, input longint target,
                                      input longint step);
        longint d;
        d = target - cur;
        if (d > step)
            d = step;
        if (d < -step)
            d = -step;
        return cur + d;
    endfunction

    function automatic logic signed [31:0] saturated(input logic signed [31:0] p,
                                                     input longint d);
        longint s;
        s = longint'(p) + d;
        if (s > POS_MAX)
            s = POS_MAX;
        if (s < POS_MIN)
            s = POS_MIN;
        return 32'(s);
    endfunction

    // vehicle state after one command transaction
    function automatic vehicle_state_t vehicle_next_state(input command_t c);
        longint             walk_target;
        longint             turn_target;
        logic [9:0]         idx;
        logic signed [15:0] cos_v;
        logic signed [15:0] sin_v;
        vehicle_state_t     s;
        if (c.cmd == CMD_SET_POS)
        begin
            veh_x = c.new_x;
            veh_y = c.new_y;
        end
        else
        begin
            walk_target = (longint'($signed(c.walk_demand)) * longint'(walk_limit)) >>> 15;
            turn_target = (longint'($signed(c.turn_demand)) * longint'(turn_limit)) >>> 15;
            veh_walk    = slewed(veh_walk, walk_target, longint'(walk_step));
            veh_turn    = slewed(veh_turn, turn_target, longint'(turn_step));
            veh_heading = veh_heading + 16'(veh_turn);
        end
        idx   = veh_heading[15:6];
        sin_v = sine_of(idx);
        cos_v = sine_of(idx + 10'(QUARTER_LEN));
        if (c.cmd == CMD_ADVANCE)
        begin
            veh_x = saturated(veh_x, (longint'(cos_v) * veh_walk) >>> 15);
            veh_y = saturated(veh_y, (longint'(sin_v) * veh_walk) >>> 15);
        end
        s.position_x    = veh_x;
        s.position_y    = veh_y;
        s.heading_phase = veh_heading;
        s.direction_x   = cos_v;
        s.direction_y   = sin_v;
        s.walk_rate     = 17'(veh_walk);
        s.turn_rate     = 15'(veh_turn);
        return s;
    endfunction

    function automatic vehicle_state_t vs(input logic signed [31:0] px,
                                          input logic signed [31:0] py,
                                          input logic [15:0] hd,
                                          input logic signed [15:0] dx,
                                          input logic signed [15:0] dy,
                                          input logic signed [16:0] wr,
                                          input logic signed [14:0] tr);
        vehicle_state_t s;
        s.position_x    = px;
        s.position_y    = py;
        s.heading_phase = hd;
        s.direction_x   = dx;
        s.direction_y   = dy;
        s.walk_rate     = wr;
        s.turn_rate     = tr;
        return s;
    endfunction

    function automatic stim_row_t row(input logic c, input logic signed [15:0] wd,
                                      input logic signed [15:0] td,
                                      input logic signed [31:0] nx,
                                      input logic signed [31:0] ny,
                                      input logic typed, input vehicle_state_t want);
        stim_row_t r;
        r.command.cmd         = c;
        r.command.walk_demand = wd;
        r.command.turn_demand = td;
        r.command.new_x       = nx;
        r.command.new_y       = ny;
        r.typed               = typed;
        r.state               = want;
        return r;
    endfunction

    function automatic logic signed [15:0] demand_extreme();
        case ($urandom_range(4))
            0:       return 16'sh8000;
            1:       return 16'shFFFF;
            2:       return 16'sh0000;
            3:       return 16'sh0001;
            default: return 16'sh7FFF;
        endcase
    endfunction

    // positions are often close to the limits so that saturation happens
    function automatic logic signed [31:0] position_sample();
        case ($urandom_range(2))
            0:       return $urandom;
            1:       return {16'h7FFF, 16'($urandom)};
            default: return {16'h8000, 16'($urandom)};
        endcase
    endfunction

    // register write, then cfg_we low again and the predictor copy updated
    task automatic write_register(input logic [CFG_INDEX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (index)
            CFG_WALK_LIMIT: walk_limit = data;
            CFG_WALK_STEP:  walk_step  = data;
            CFG_TURN_LIMIT: turn_limit = data[13:0];
            CFG_TURN_STEP:  turn_step  = data[13:0];
            default:        ;
        endcase
    endtask

    // one command transaction, with a random gap before it
    task automatic send_command(input command_t c, input logic typed,
                                input vehicle_state_t typed_state);
        vehicle_state_t s;
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_ch.valid       <= 1'b1;
        cmd_ch.cmd         <= c.cmd;
        cmd_ch.walk_demand <= c.walk_demand;
        cmd_ch.turn_demand <= c.turn_demand;
        cmd_ch.new_x       <= c.new_x;
        cmd_ch.new_y       <= c.new_y;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        s = vehicle_next_state(c);
        pending_states.push_back(typed ? typed_state : s);
    endtask

    // hold off until every expected result has been taken
    task automatic wait_for_drain();
        cmd_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_states.size() != 0)
            @(posedge clk);
    endtask

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got)
        begin
            error_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // result side stalls
    initial
    begin
        state_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            state_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // compare each result transaction with the oldest expected state
    always @(posedge clk)
    begin : check_results
        vehicle_state_t want;
        if (rst_n && state_ch.valid && state_ch.ready)
        begin
            if (pending_states.size() == 0)
            begin
                error_count++;
                $display("%0t: result with none expected, expected nothing, actual x %0d y %0d",
                         $time, state_ch.position_x, state_ch.position_y);
            end
            else
            begin
                want = pending_states.pop_front();
                check_field("position_x", want.position_x, state_ch.position_x);
                check_field("position_y", want.position_y, state_ch.position_y);
                check_field("heading_phase", want.heading_phase, state_ch.heading_phase);
                check_field("direction_x", want.direction_x, state_ch.direction_x);
                check_field("direction_y", want.direction_y, state_ch.direction_y);
                check_field("walk_rate", want.walk_rate, state_ch.walk_rate);
                check_field("turn_rate", want.turn_rate, state_ch.turn_rate);
            end
        end
    end

    // run time limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // stimulus
    initial
    begin : stimulus
        stim_row_t          directed_rows [$];
        command_t           c;
        logic signed [15:0] held_walk;
        logic signed [15:0] held_turn;
        logic        [15:0] wl;
        logic        [15:0] ws;
        logic        [15:0] tl;
        logic        [15:0] ts;
        logic               pause_phase;
        int                 p;
        int                 k;
        int                 issued;
        int                 run_len;
        int                 r;

        // known inputs and predictor reset state
        rst_n              <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_index          <= '0;
        cfg_data           <= '0;
        cmd_ch.valid       <= 1'b0;
        cmd_ch.cmd         <= CMD_ADVANCE;
        cmd_ch.walk_demand <= '0;
        cmd_ch.turn_demand <= '0;
        cmd_ch.new_x       <= '0;
        cmd_ch.new_y       <= '0;
        walk_limit  = WALK_LIMIT_RST;
        walk_step   = WALK_STEP_RST;
        turn_limit  = TURN_LIMIT_RST;
        turn_step   = TURN_STEP_RST;
        veh_x       = '0;
        veh_y       = '0;
        veh_heading = '0;
        veh_walk    = 0;
        veh_turn    = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // unmapped register indexes must be ignored
        for (k = 0; k < 4; k++)
            write_register(CFG_UNMAPPED_BASE + 3'(k), 16'hFFFF);

        // directed table, reset register values
        // reset state: direction derived from heading zero
        directed_rows.push_back(row(CMD_ADVANCE, 16'sh0000, 16'sh0000, 32'sh0, 32'sh0,
                                    1'b1, vs(0, 0, 0, 32767, 0, 0, 0)));
        // set position to a corner, demands ignored and speeds held
        directed_rows.push_back(row(CMD_SET_POS, 16'sh7FFF, 16'sh8000,
                                    32'sh7FFFFFFF, 32'sh80000000, 1'b1,
                                    vs(32'sh7FFFFFFF, 32'sh80000000, 0, 32767, 0, 0, 0)));
        // full forward from the corner, x saturates high
        for (k = 0; k < 3; k++)
            directed_rows.push_back(row(CMD_ADVANCE, 16'sh7FFF, 16'sh0000, 32'sh0, 32'sh0,
                                        1'b0, '0));
        // full turn both ways at the reset limits
        for (k = 0; k < 4; k++)
            directed_rows.push_back(row(CMD_ADVANCE, 16'sh7FFF, 16'sh7FFF, 32'sh0, 32'sh0,
                                        1'b0, '0));
        for (k = 0; k < 4; k++)
            directed_rows.push_back(row(CMD_ADVANCE, 16'sh8000, 16'sh8000, 32'sh0, 32'sh0,
                                        1'b0, '0));
        // opposite corner while moving
        directed_rows.push_back(row(CMD_SET_POS, 16'sh0000, 16'sh0000,
                                    32'sh80000000, 32'sh7FFFFFFF, 1'b0, '0));
        for (k = 0; k < 2; k++)
            directed_rows.push_back(row(CMD_ADVANCE, 16'sh8000, 16'sh0000, 32'sh0, 32'sh0,
                                        1'b0, '0));
        // smallest demands and mixed signs
        directed_rows.push_back(row(CMD_ADVANCE, 16'sh0001, 16'shFFFF, 32'sh0, 32'sh0,
                                    1'b0, '0));
        directed_rows.push_back(row(CMD_ADVANCE, 16'shFFFF, 16'sh0001, 32'sh0, 32'sh0,
                                    1'b0, '0));
        directed_rows.push_back(row(CMD_ADVANCE, 16'sh4000, 16'shC000, 32'sh0, 32'sh0,
                                    1'b0, '0));
        for (k = 0; k < 2; k++)
            directed_rows.push_back(row(CMD_ADVANCE, 16'sh7FFF, 16'sh8000, 32'sh0, 32'sh0,
                                        1'b0, '0));
        directed_rows.push_back(row(CMD_SET_POS, 16'sh7FFF, 16'sh7FFF, 32'sh0, 32'sh0,
                                    1'b0, '0));
        directed_rows.push_back(row(CMD_ADVANCE, 16'sh0000, 16'sh0000, 32'sh0, 32'sh0,
                                    1'b0, '0));

        send_idle_pct  = 16;
        recv_stall_pct = 16;
        foreach (directed_rows[i])
            send_command(directed_rows[i].command, directed_rows[i].typed,
                         directed_rows[i].state);

        // random phases, each with its own registers and idling
        for (p = 0; p < NUM_PHASES; p++)
        begin
            wait_for_drain();
            repeat (SETTLE_CYCLES) @(posedge clk);
            case (p)
                0:
                begin
                    wl = WALK_LIMIT_RST; ws = WALK_STEP_RST;
                    tl = 16'(TURN_LIMIT_RST); ts = 16'(TURN_STEP_RST);
                    send_idle_pct = 0;  recv_stall_pct = 0;
                end
                1:
                begin
                    // all ones, turn registers keep only their low bits
                    wl = 16'hFFFF; ws = 16'hFFFF; tl = 16'hFFFF; ts = 16'hFFFF;
                    send_idle_pct = 64; recv_stall_pct = 0;
                end
                2:
                begin
                    // limits dropped below the current speeds
                    wl = 16'd0; ws = 16'd100; tl = 16'd0; ts = 16'd50;
                    send_idle_pct = 0;  recv_stall_pct = 64;
                end
                3:
                begin
                    wl = 16'd65535; ws = 16'd1; tl = 16'd16383; ts = 16'd1;
                    send_idle_pct = 16; recv_stall_pct = 16;
                end
                4:
                begin
                    wl = 16'd0; ws = 16'd65535; tl = 16'd0; ts = 16'd16383;
                    send_idle_pct = 0;  recv_stall_pct = 0;
                end
                5:
                begin
                    wl = 16'($urandom); ws = 16'($urandom);
                    tl = 16'($urandom); ts = 16'($urandom);
                    send_idle_pct = 64; recv_stall_pct = 0;
                end
                6:
                begin
                    // zero steps freeze the speeds
                    wl = 16'd65535; ws = 16'd0; tl = 16'd16383; ts = 16'd0;
                    send_idle_pct = 0;  recv_stall_pct = 64;
                end
                default:
                begin
                    wl = 16'($urandom); ws = 16'($urandom_range(4000));
                    tl = 16'($urandom); ts = 16'($urandom_range(2000));
                    send_idle_pct = 16; recv_stall_pct = 16;
                end
            endcase
            write_register(CFG_WALK_LIMIT, wl);
            write_register(CFG_WALK_STEP, ws);
            write_register(CFG_TURN_LIMIT, tl);
            write_register(CFG_TURN_STEP, ts);
            pause_phase = (p % 4 == 0);

            // runs of held demands so speeds reach their targets
            issued = 0;
            while (issued < ITEMS_PER_PHASE)
            begin
                run_len = $urandom_range(16, 1);
                if ($urandom_range(3) == 0)
                begin
                    held_walk = demand_extreme();
                    held_turn = demand_extreme();
                end
                else
                begin
                    held_walk = 16'($urandom);
                    held_turn = 16'($urandom);
                end
                for (k = 0; k < run_len && issued < ITEMS_PER_PHASE; k++)
                begin
                    c.cmd         = CMD_ADVANCE;
                    c.walk_demand = held_walk;
                    c.turn_demand = held_turn;
                    c.new_x       = $urandom;
                    c.new_y       = $urandom;
                    r = $urandom_range(99);
                    if (r < 8)
                    begin
                        c.cmd   = CMD_SET_POS;
                        c.new_x = position_sample();
                        c.new_y = position_sample();
                    end
                    else if (r < 16)
                    begin
                        c.walk_demand = 16'($urandom);
                        c.turn_demand = 16'($urandom);
                    end
                    send_command(c, 1'b0, '0);
                    issued++;
                    if (pause_phase && issued % PAUSE_EVERY == 0)
                        wait_for_drain();
                end
            end
        end

        // drain and report
        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
